>>> sv/iirc_pkg.sv
// ----------------------------------------------------------------------------
// iirc_pkg
// Shared widths, register indexes, control word layout and the microcode
// program of the three-stage IIR compensator.
// ----------------------------------------------------------------------------
package iirc_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int STATE_WIDTH_DEF = 48;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 32;
   localparam int DRIVE_W   = 32;
   localparam int CSR_IDX_W = 4;
   localparam int NUM_REGS  = 8;
   localparam int REG_IDX_W = $clog2(NUM_REGS);

   // multiplier operand is widened to MUL_W and taken in two halves
   localparam int MUL_W  = 64;
   localparam int HALF_W = MUL_W / 2;

   localparam int PROG_LEN = 22;
   localparam int STEP_W   = $clog2(PROG_LEN);

   localparam logic [COEF_W-1:0]  UNITY     = 32'h0001_0000;
   localparam logic [DRIVE_W-1:0] DRIVE_MAX = 32'h7FFF_FFFF;
   localparam logic [DRIVE_W-1:0] DRIVE_MIN = 32'h8000_0000;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_A_POLE   = 3'd0,
      REG_A_ZERO   = 3'd1,
      REG_B_POLE   = 3'd2,
      REG_C_POLE   = 3'd3,
      REG_FF_GAIN  = 3'd4,
      REG_C_GAIN   = 3'd5,
      REG_A_GAIN   = 3'd6,
      REG_OUT_GAIN = 3'd7
   } reg_idx_type;

   localparam logic [COEF_W-1:0] CFG_RESET [NUM_REGS] =
      '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, UNITY, UNITY};

   typedef enum logic [1:0] {
      MOP_NONE = 2'd0,
      MOP_LO   = 2'd1,
      MOP_HI   = 2'd2
   } mop_type;

   typedef enum logic [2:0] {
      MS_XQ  = 3'd0,
      MS_ACC = 3'd1,
      MS_CY1 = 3'd2,
      MS_AX1 = 3'd3,
      MS_AY1 = 3'd4,
      MS_BY1 = 3'd5
   } msrc_type;

   typedef enum logic [1:0] {
      AOP_NONE = 2'd0,
      AOP_LOAD = 2'd1,
      AOP_ADD  = 2'd2,
      AOP_SUB  = 2'd3
   } aop_type;

   typedef enum logic [1:0] {
      AS_XQ  = 2'd0,
      AS_CX1 = 2'd1,
      AS_BX1 = 2'd2,
      AS_PRD = 2'd3
   } asrc_type;

   typedef enum logic [2:0] {
      WR_NONE = 3'd0,
      WR_TMP  = 3'd1,
      WR_C    = 3'd2,
      WR_A    = 3'd3,
      WR_B    = 3'd4
   } wr_type;

   typedef enum logic [1:0] {
      JC_NEXT = 2'd0,
      JC_IN   = 2'd1,
      JC_OUT  = 2'd2,
      JC_JUMP = 2'd3
   } jc_type;

   typedef struct packed {
      mop_type     mop;
      msrc_type    msrc;
      reg_idx_type coef;
      logic        fin;
      aop_type     aop;
      asrc_type    asrc;
      wr_type      wr;
      jc_type      jc;
      step_type    target;
      logic        publish;
   } ctrl_type;

   typedef struct packed {
      logic in_valid;
      logic out_free;
   } stat_type;

   // microcode: a product takes a LO and a HI pass, the FIN step after HI
   // scales and clamps it into the product register
   function automatic ctrl_type ucode(step_type s);
      ctrl_type w;
      w.mop     = MOP_NONE;
      w.msrc    = MS_XQ;
      w.coef    = REG_A_POLE;
      w.fin     = 1'b0;
      w.aop     = AOP_NONE;
      w.asrc    = AS_XQ;
      w.wr      = WR_NONE;
      w.jc      = JC_NEXT;
      w.target  = '0;
      w.publish = 1'b0;
      unique case (s)
         5'd0: begin
            w.mop = MOP_LO; w.msrc = MS_CY1; w.coef = REG_C_POLE; w.jc = JC_IN;
         end
         5'd1: begin
            w.mop = MOP_HI; w.msrc = MS_CY1; w.coef = REG_C_POLE;
            w.aop = AOP_LOAD; w.asrc = AS_XQ;
         end
         5'd2: begin
            w.fin = 1'b1; w.mop = MOP_LO; w.msrc = MS_XQ; w.coef = REG_FF_GAIN;
            w.aop = AOP_SUB; w.asrc = AS_CX1;
         end
         5'd3: begin
            w.mop = MOP_HI; w.msrc = MS_XQ; w.coef = REG_FF_GAIN;
            w.aop = AOP_ADD; w.asrc = AS_PRD;
         end
         5'd4: begin
            w.fin = 1'b1; w.mop = MOP_LO; w.msrc = MS_ACC; w.coef = REG_C_GAIN;
            w.wr = WR_C;
         end
         5'd5: begin
            w.mop = MOP_HI; w.msrc = MS_ACC; w.coef = REG_C_GAIN;
            w.aop = AOP_LOAD; w.asrc = AS_PRD;
         end
         5'd6: begin
            w.fin = 1'b1; w.mop = MOP_LO; w.msrc = MS_AX1; w.coef = REG_A_ZERO;
         end
         5'd7: begin
            w.mop = MOP_HI; w.msrc = MS_AX1; w.coef = REG_A_ZERO;
            w.aop = AOP_ADD; w.asrc = AS_PRD;
         end
         5'd8: begin
            w.fin = 1'b1; w.mop = MOP_LO; w.msrc = MS_AY1; w.coef = REG_A_POLE;
            w.wr = WR_TMP;
         end
         5'd9: begin
            w.mop = MOP_HI; w.msrc = MS_AY1; w.coef = REG_A_POLE;
            w.aop = AOP_ADD; w.asrc = AS_PRD;
         end
         5'd10: begin
            w.fin = 1'b1;
         end
         5'd11: begin
            w.aop = AOP_ADD; w.asrc = AS_PRD;
         end
         5'd12: begin
            w.mop = MOP_LO; w.msrc = MS_ACC; w.coef = REG_A_GAIN; w.wr = WR_A;
         end
         5'd13: begin
            w.mop = MOP_HI; w.msrc = MS_ACC; w.coef = REG_A_GAIN;
         end
         5'd14: begin
            w.fin = 1'b1; w.mop = MOP_LO; w.msrc = MS_BY1; w.coef = REG_B_POLE;
         end
         5'd15: begin
            w.mop = MOP_HI; w.msrc = MS_BY1; w.coef = REG_B_POLE;
            w.aop = AOP_LOAD; w.asrc = AS_PRD;
         end
         5'd16: begin
            w.fin = 1'b1; w.aop = AOP_ADD; w.asrc = AS_BX1; w.wr = WR_TMP;
         end
         5'd17: begin
            w.aop = AOP_ADD; w.asrc = AS_PRD;
         end
         5'd18: begin
            w.mop = MOP_LO; w.msrc = MS_ACC; w.coef = REG_OUT_GAIN; w.wr = WR_B;
         end
         5'd19: begin
            w.mop = MOP_HI; w.msrc = MS_ACC; w.coef = REG_OUT_GAIN;
         end
         5'd20: begin
            w.fin = 1'b1;
         end
         5'd21: begin
            w.publish = 1'b1; w.jc = JC_OUT; w.target = '0;
         end
         default: begin
            w.jc = JC_JUMP; w.target = '0;
         end
      endcase
      return w;
   endfunction

endpackage

>>> sv/iirc_if.sv
// ----------------------------------------------------------------------------
// iirc channel interfaces
// Valid/ready channels for sample words, result words and register writes.
// ----------------------------------------------------------------------------
interface iirc_req_if import iirc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] error_sample;
   modport source (output valid, output error_sample, input ready);
   modport sink (input valid, input error_sample, output ready);
endinterface

interface iirc_rsp_if import iirc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive_value;
   logic                      saturated;
   modport source (output valid, output drive_value, output saturated, input ready);
   modport sink (input valid, input drive_value, input saturated, output ready);
endinterface

interface iirc_csr_if import iirc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COEF_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/iirc_sequencer.sv
// ----------------------------------------------------------------------------
// iirc_sequencer
// Step counter over the microcode table, with wait-for-sample and
// wait-for-output-slot jumps.
// ----------------------------------------------------------------------------
module iirc_sequencer import iirc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctrl_type ctrl,
   output logic     in_ready
);

   step_type step_ff, step_in;

   always_comb begin
      ctrl     = ucode(step_ff);
      in_ready = (ctrl.jc == JC_IN);
      unique case (ctrl.jc)
         JC_NEXT: step_in = step_ff + 1'b1;
         JC_IN:   step_in = stat.in_valid ? step_ff + 1'b1 : step_ff;
         JC_OUT:  step_in = stat.out_free ? ctrl.target : step_ff;
         JC_JUMP: step_in = ctrl.target;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

>>> sv/iirc_mul.sv
// ----------------------------------------------------------------------------
// iirc_mul
// Shared 32x32 multiplier: two passes per product, then floor scaling by
// the fraction bits and clamping to the state width.
// ----------------------------------------------------------------------------
module iirc_mul import iirc_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
   input  logic                          clock,
   input  mop_type                       mop,
   input  logic                          fin,
   input  logic signed [STATE_WIDTH-1:0] opd,
   input  logic signed [COEF_W-1:0]      coef,
   output logic signed [STATE_WIDTH-1:0] prd,
   output logic                          fin_sat
);

   localparam int SW     = STATE_WIDTH;
   localparam int FULL_W = MUL_W + COEF_W;
   localparam logic signed [SW-1:0] ST_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] ST_MIN = {1'b1, {(SW-1){1'b0}}};

   logic signed [MUL_W-1:0]         opd_ext;
   logic signed [HALF_W:0]          half_opd;
   logic signed [HALF_W+COEF_W:0]   pp_in;
   logic signed [HALF_W+COEF_W:0]   pp_lo_ff;
   logic signed [HALF_W+COEF_W-1:0] pp_hi_ff;
   logic signed [FULL_W-1:0]        full, quo;
   logic [FULL_W-SW:0]              top_bits;
   logic signed [SW-1:0]            prd_ff, prd_in;

   always_comb begin
      opd_ext = MUL_W'(opd);
      // low half is taken unsigned, high half carries the sign
      if (mop == MOP_HI) begin
         half_opd = {opd_ext[MUL_W-1], opd_ext[MUL_W-1:HALF_W]};
      end else begin
         half_opd = {1'b0, opd_ext[HALF_W-1:0]};
      end
      pp_in    = half_opd * coef;
      // recombine the halves, arithmetic shift gives the floor
      full     = (FULL_W'(pp_hi_ff) <<< HALF_W) + FULL_W'(pp_lo_ff);
      quo      = full >>> FRAC_BITS;
      top_bits = quo[FULL_W-1:SW-1];
      fin_sat  = !((&top_bits) || (~|top_bits));
      if (fin_sat) begin
         prd_in = quo[FULL_W-1] ? ST_MIN : ST_MAX;
      end else begin
         prd_in = quo[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mop == MOP_LO) begin
         pp_lo_ff <= pp_in;
      end
      if (mop == MOP_HI) begin
         pp_hi_ff <= pp_in[HALF_W+COEF_W-1:0];
      end
      if (fin) begin
         prd_ff <= prd_in;
      end
   end

   assign prd = prd_ff;

endmodule

>>> sv/iirc_datapath.sv
// ----------------------------------------------------------------------------
// iirc_datapath
// Coefficient registers, section state, saturating accumulator and the
// result register, steered by the control word.
// ----------------------------------------------------------------------------
module iirc_datapath import iirc_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctrl_type                   ctrl,
   input  logic                       in_fire,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic                       csr_fire,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [COEF_W-1:0]          csr_data,
   input  logic                       rsp_ready,
   output logic                       out_free,
   output logic                       rsp_valid,
   output logic signed [DRIVE_W-1:0]  drive_value,
   output logic                       saturated
);

   localparam int SW  = STATE_WIDTH;
   localparam int SW1 = SW + 1;
   localparam int XW  = (SAMPLE_W + FRAC_BITS > SW) ? SAMPLE_W + FRAC_BITS : SW;
   localparam logic signed [SW-1:0] ST_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] ST_MIN = {1'b1, {(SW-1){1'b0}}};

   logic [COEF_W-1:0]    cfg_ff [NUM_REGS];
   logic signed [SW-1:0] xq_ff, acc_ff, acc_in, tmp_ff;
   logic signed [SW-1:0] cx1_ff, cy1_ff, ax1_ff, ay1_ff, bx1_ff, by1_ff;
   logic                 sat_ff, rsp_valid_ff, rsp_sat_ff;
   logic signed [DRIVE_W-1:0] drive_ff, drive_in;

   logic signed [XW-1:0] xw;
   logic [XW-SW:0]       x_top;
   logic signed [SW-1:0] xq_in;
   logic                 xq_sat;

   logic signed [SW-1:0] mul_opd, alu_src, prd;
   logic signed [COEF_W-1:0] mul_coef;
   logic                 fin_sat;

   logic signed [SW1-1:0] a_ext, b_ext, sum;
   logic                  alu_sat;
   logic [SW-DRIVE_W:0]   d_top;
   logic                  out_sat, publish_fire;

   iirc_mul #(
      .FRAC_BITS   (FRAC_BITS),
      .STATE_WIDTH (STATE_WIDTH)
   ) u_mul (
      .clock   (clock),
      .mop     (ctrl.mop),
      .fin     (ctrl.fin),
      .opd     (mul_opd),
      .coef    (mul_coef),
      .prd     (prd),
      .fin_sat (fin_sat)
   );

   // sample scaling into the state format
   always_comb begin
      xw     = XW'(sample) <<< FRAC_BITS;
      x_top  = xw[XW-1:SW-1];
      xq_sat = !((&x_top) || (~|x_top));
      if (xq_sat) begin
         xq_in = xw[XW-1] ? ST_MIN : ST_MAX;
      end else begin
         xq_in = xw[SW-1:0];
      end
   end

   always_comb begin
      mul_coef = cfg_ff[ctrl.coef];
      unique case (ctrl.msrc)
         MS_XQ:   mul_opd = xq_ff;
         MS_ACC:  mul_opd = acc_ff;
         MS_CY1:  mul_opd = cy1_ff;
         MS_AX1:  mul_opd = ax1_ff;
         MS_AY1:  mul_opd = ay1_ff;
         MS_BY1:  mul_opd = by1_ff;
         default: mul_opd = xq_ff;
      endcase
   end

   // saturating accumulator
   always_comb begin
      unique case (ctrl.asrc)
         AS_XQ:  alu_src = xq_ff;
         AS_CX1: alu_src = cx1_ff;
         AS_BX1: alu_src = bx1_ff;
         AS_PRD: alu_src = prd;
      endcase
      a_ext = SW1'(acc_ff);
      b_ext = SW1'(alu_src);
      sum   = (ctrl.aop == AOP_SUB) ? a_ext - b_ext : a_ext + b_ext;
      alu_sat = 1'b0;
      unique case (ctrl.aop)
         AOP_NONE: acc_in = acc_ff;
         AOP_LOAD: acc_in = alu_src;
         AOP_ADD, AOP_SUB: begin
            alu_sat = (sum[SW] != sum[SW-1]);
            if (alu_sat) begin
               acc_in = sum[SW] ? ST_MIN : ST_MAX;
            end else begin
               acc_in = sum[SW-1:0];
            end
         end
      endcase
   end

   // result clamp to the drive range
   always_comb begin
      d_top   = prd[SW-1:DRIVE_W-1];
      out_sat = !((&d_top) || (~|d_top));
      if (out_sat) begin
         drive_in = prd[SW-1] ? DRIVE_MIN : DRIVE_MAX;
      end else begin
         drive_in = prd[DRIVE_W-1:0];
      end
      out_free     = !rsp_valid_ff || rsp_ready;
      publish_fire = ctrl.publish && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         cx1_ff       <= '0;
         cy1_ff       <= '0;
         ax1_ff       <= '0;
         ay1_ff       <= '0;
         bx1_ff       <= '0;
         by1_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
            cfg_ff[csr_index[REG_IDX_W-1:0]] <= csr_data;
         end
         unique case (ctrl.wr)
            WR_C: begin
               cx1_ff <= xq_ff;
               cy1_ff <= acc_ff;
            end
            WR_A: begin
               ax1_ff <= tmp_ff;
               ay1_ff <= acc_ff;
            end
            WR_B: begin
               bx1_ff <= tmp_ff;
               by1_ff <= acc_ff;
            end
            default: begin
            end
         endcase
         if (in_fire) begin
            sat_ff <= xq_sat;
         end else begin
            sat_ff <= sat_ff | alu_sat | (ctrl.fin & fin_sat);
         end
         if (publish_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         xq_ff <= xq_in;
      end
      acc_ff <= acc_in;
      if (ctrl.wr == WR_TMP) begin
         tmp_ff <= acc_ff;
      end
      if (publish_fire) begin
         drive_ff   <= drive_in;
         rsp_sat_ff <= sat_ff | out_sat;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign drive_value = drive_ff;
   assign saturated   = rsp_sat_ff;

endmodule

>>> sv/three_stage_iir_compensator_top.sv
// ----------------------------------------------------------------------------
// three_stage_iir_compensator_top
// Cascade of a differentiator, a pole-zero and an integrator section in
// fixed point, run by a microcoded sequencer over one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  direction  payload                      handshake
//  req_ch   in         error_sample                 valid/ready
//  rsp_ch   out        drive_value, saturated       valid/ready
//  csr_ch   in         index, data                  valid/ready, ready out of reset
//
// eight products on the shared 32x32 multiplier, each a low and a high pass
// plus a scaling step, make up the program; a new word is taken only once
// the program for the previous one has run; the result is registered at its last step
// a sample is taken while the previous result still waits in its register;
// the last step holds while that register is full and not being read
// synchronous reset loads the reset coefficients and clears section state and the step counter
// ----------------------------------------------------------------------------
module three_stage_iir_compensator_top import iirc_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   iirc_req_if.sink   req_ch,
   iirc_rsp_if.source rsp_ch,
   iirc_csr_if.sink   csr_ch
);

   ctrl_type ctrl;
   stat_type stat;
   logic     in_ready, in_fire, out_free;

   assign stat.in_valid = req_ch.valid;
   assign stat.out_free = out_free;
   assign req_ch.ready  = in_ready && !reset;
   assign in_fire       = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = !reset;

   iirc_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .stat     (stat),
      .ctrl     (ctrl),
      .in_ready (in_ready)
   );

   iirc_datapath #(
      .FRAC_BITS   (FRAC_BITS),
      .STATE_WIDTH (STATE_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .in_fire     (in_fire),
      .sample      (req_ch.error_sample),
      .csr_fire    (csr_ch.valid && csr_ch.ready),
      .csr_index   (csr_ch.index),
      .csr_data    (csr_ch.data),
      .rsp_ready   (rsp_ch.ready),
      .out_free    (out_free),
      .rsp_valid   (rsp_ch.valid),
      .drive_value (rsp_ch.drive_value),
      .saturated   (rsp_ch.saturated)
   );

endmodule

>>> sv/iirc_checker.sv
// ----------------------------------------------------------------------------
// iirc_checker
// Port-level checks on the compensator: result hold, busy window and
// program length.
// ----------------------------------------------------------------------------
module iirc_checker import iirc_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [DRIVE_W-1:0] drive_value,
   input logic                      saturated
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(drive_value) && $stable(saturated))
      else $error("result word changed while stalled");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample taken while previous word still in work");

   a_busy_to_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##(PROG_LEN - 1) !req_ready)
      else $error("program ended early");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result word appeared while waiting for a sample");

endmodule

bind three_stage_iir_compensator_top iirc_checker u_iirc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .drive_value (rsp_ch.drive_value),
   .saturated   (rsp_ch.saturated)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-stage IIR compensator. Sample words are
// queued by the stimulus block and fed by a clocked driver; each accepted
// sample is run through a bit-true fixed-point model of the three sections,
// and the monitor compares every drive word against the oldest prediction.
// Coefficients are reloaded between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb;
   import iirc_pkg::*;

   localparam int FB             = FRAC_BITS_DEF;
   localparam int SW             = STATE_WIDTH_DEF;
   localparam int ONE_Q          = 65536;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 40;

   typedef logic signed [127:0] wide_type;
   typedef logic signed [63:0]  state_type;

   localparam wide_type  STATE_HI = (wide_type'(1) <<< (SW - 1)) - 1;
   localparam wide_type  STATE_LO = -STATE_HI - 1;
   localparam state_type DRIVE_HI = 64'sh7FFF_FFFF;
   localparam state_type DRIVE_LO = -DRIVE_HI - 1;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive_value;
      logic                      saturated;
   } drive_word_type;

   typedef struct {
      logic [CSR_IDX_W-1:0] idx;
      logic [COEF_W-1:0]    val;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   iirc_req_if req_ch ();
   iirc_rsp_if rsp_ch ();
   iirc_csr_if csr_ch ();

   three_stage_iir_compensator_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // coefficient copy and section state of the model
   logic signed [COEF_W-1:0] coef_reg [NUM_REGS];
   state_type c_x1 = '0, c_y1 = '0, a_x1 = '0, a_y1 = '0, b_x1 = '0, b_y1 = '0;
   bit        clip_seen;

   logic signed [SAMPLE_W-1:0] pending_samples [$];
   drive_word_type             expected_drive_q [$];
   reg_write_type              reg_batch [$];

   int             send_gap     = 0;
   int             rsp_stall    = 0;
   int             burst_odds   = 0;
   int             mismatches   = 0;
   int             quiet_cycles = 0;
   drive_word_type want;

   function automatic state_type q_clip(input wide_type v);
      if (v > STATE_HI) begin
         clip_seen = 1'b1;
         return state_type'(STATE_HI);
      end
      if (v < STATE_LO) begin
         clip_seen = 1'b1;
         return state_type'(STATE_LO);
      end
      return state_type'(v);
   endfunction

   // product scaled back by the fraction width, floor rounding
   function automatic state_type q_mul(input state_type v,
                                       input logic signed [COEF_W-1:0] c);
      wide_type p;
      p = wide_type'(v) * wide_type'(c);
      return q_clip(p >>> FB);
   endfunction

   function automatic state_type q_add(input state_type a, input state_type b);
      return q_clip(wide_type'(a) + wide_type'(b));
   endfunction

   function automatic state_type q_sub(input state_type a, input state_type b);
      return q_clip(wide_type'(a) - wide_type'(b));
   endfunction

   function automatic drive_word_type compensate_sample(input logic signed [SAMPLE_W-1:0] x);
      state_type      xq, c, s, a, ya, b, y;
      drive_word_type w;
      clip_seen = 1'b0;
      xq = q_clip(wide_type'(x) <<< FB);
      c = q_add(q_sub(xq, c_x1), q_mul(c_y1, coef_reg[REG_C_POLE]));
      c_x1 = xq;
      c_y1 = c;
      s = q_add(q_mul(xq, coef_reg[REG_FF_GAIN]), q_mul(c, coef_reg[REG_C_GAIN]));
      a = q_add(q_add(s, q_mul(a_x1, coef_reg[REG_A_ZERO])),
                q_mul(a_y1, coef_reg[REG_A_POLE]));
      a_x1 = s;
      a_y1 = a;
      ya = q_mul(a, coef_reg[REG_A_GAIN]);
      b = q_add(q_add(ya, b_x1), q_mul(b_y1, coef_reg[REG_B_POLE]));
      b_x1 = ya;
      b_y1 = b;
      y = q_mul(b, coef_reg[REG_OUT_GAIN]);
      if (y > DRIVE_HI) begin
         y = DRIVE_HI;
         clip_seen = 1'b1;
      end
      if (y < DRIVE_LO) begin
         y = DRIVE_LO;
         clip_seen = 1'b1;
      end
      w.drive_value = y[DRIVE_W-1:0];
      w.saturated   = clip_seen;
      return w;
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef(input int mode);
      case (mode)
         0: return COEF_W'($urandom_range(0, 2 * ONE_Q) - ONE_Q);
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               default: return 32'h0;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sh0000;
               3: return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         1, 2: return SAMPLE_W'($urandom_range(0, 128) - 64);
         3: return SAMPLE_W'($urandom_range(0, 4096) - 2048);
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_drive_q.push_back(compensate_sample(req_ch.error_sample));
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_ch.error_sample <= pending_samples.pop_front();
               req_ch.valid        <= 1'b1;
               if (burst_odds != 0 && $urandom_range(1, burst_odds) == 1)
                  send_gap = $urandom_range(1, 11);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // drive word monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_drive_q.size() == 0) begin
               if (mismatches < 10)
                  $display("tb: unexpected drive word %0d sat %0b",
                           rsp_ch.drive_value, rsp_ch.saturated);
               mismatches++;
            end else begin
               want = expected_drive_q.pop_front();
               if (rsp_ch.drive_value !== want.drive_value ||
                   rsp_ch.saturated !== want.saturated) begin
                  if (mismatches < 10)
                     $display("tb: drive word mismatch: expected %0d sat %0b, got %0d sat %0b",
                              want.drive_value, want.saturated,
                              rsp_ch.drive_value, rsp_ch.saturated);
                  mismatches++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (burst_odds != 0 && $urandom_range(1, burst_odds) == 1)
               rsp_stall = $urandom_range(1, 11);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // checked mid-cycle so the driver's updates of this edge are settled
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_ch.valid || expected_drive_q.size() != 0);
      @(posedge clock);
   endtask

   // only called with the block drained
   task automatic load_regs();
      foreach (reg_batch[i]) begin
         csr_ch.index <= reg_batch[i].idx;
         csr_ch.data  <= reg_batch[i].val;
         csr_ch.valid <= 1'b1;
         do @(posedge clock);
         while (!csr_ch.ready);
         if (reg_batch[i].idx < NUM_REGS)
            coef_reg[reg_batch[i].idx[REG_IDX_W-1:0]] = reg_batch[i].val;
      end
      csr_ch.valid <= 1'b0;
      reg_batch.delete();
   endtask

   task automatic push_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
      reg_write_type w;
      w.idx = idx;
      w.val = val;
      reg_batch.push_back(w);
   endtask

   initial begin
      int mode;
      int n_items;
      req_ch.valid        = 1'b0;
      req_ch.error_sample = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = '0;
      csr_ch.data         = '0;
      foreach (coef_reg[i])
         coef_reg[i] = '0;
      coef_reg[REG_A_GAIN]   = ONE_Q;
      coef_reg[REG_OUT_GAIN] = ONE_Q;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset coefficients: no path from sample to drive
      pending_samples = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sd1, -16'sd1};
      wait_idle();

      // well-behaved loop, plus a write to an unused index
      push_reg(REG_C_POLE, 32'h0000_8000);
      push_reg(REG_FF_GAIN, UNITY);
      push_reg(REG_C_GAIN, 32'h0000_8000);
      push_reg(REG_A_ZERO, 32'hFFFF_C000);
      push_reg(REG_A_POLE, 32'h0000_C000);
      push_reg(REG_A_GAIN, UNITY);
      push_reg(REG_B_POLE, UNITY);
      push_reg(REG_OUT_GAIN, 32'h0000_8000);
      push_reg(CSR_IDX_W'(NUM_REGS + 3), 32'hDEAD_BEEF);
      load_regs();
      pending_samples = '{16'sh7FFF, 16'sh8000, 16'sd100, -16'sd100, 16'sd3, -16'sd3, 16'sh0000};
      wait_idle();

      // extreme coefficients drive the section state into its clamps
      push_reg(REG_C_POLE, 32'h7FFF_FFFF);
      push_reg(REG_FF_GAIN, 32'h8000_0000);
      push_reg(REG_C_GAIN, 32'h7FFF_FFFF);
      push_reg(REG_A_ZERO, 32'h8000_0000);
      push_reg(REG_A_POLE, 32'h7FFF_FFFF);
      push_reg(REG_A_GAIN, 32'h7FFF_FFFF);
      push_reg(REG_B_POLE, 32'h8000_0000);
      push_reg(REG_OUT_GAIN, 32'h7FFF_FFFF);
      load_regs();
      pending_samples = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, -16'sd1};
      wait_idle();

      // tiny coefficients expose floor rounding of negative products
      push_reg(REG_C_POLE, 32'hFFFF_FFFF);
      push_reg(REG_FF_GAIN, 32'h0000_0003);
      push_reg(REG_C_GAIN, 32'hFFFF_FFFD);
      push_reg(REG_A_ZERO, 32'h0000_0001);
      push_reg(REG_A_POLE, 32'hFFFF_FFFF);
      push_reg(REG_A_GAIN, 32'h0000_7FFF);
      push_reg(REG_B_POLE, 32'hFFFF_0001);
      push_reg(REG_OUT_GAIN, 32'h0001_0001);
      load_regs();
      pending_samples = '{-16'sd1, 16'sd1, -16'sd7, 16'sd5};
      wait_idle();

      for (int p = 0; p < 11; p++) begin
         case ($urandom_range(0, 2))
            0: burst_odds = 3;
            1: burst_odds = 6;
            default: burst_odds = 20;
         endcase
         // no idling in the last part of the run
         if (p == 10)
            burst_odds = 0;
         mode = $urandom_range(0, 3);
         for (int r = 0; r < NUM_REGS; r++)
            push_reg(CSR_IDX_W'(r), pick_coef(mode == 1 ? $urandom_range(0, 3) : mode));
         if ($urandom_range(0, 2) == 0)
            push_reg(CSR_IDX_W'(NUM_REGS + $urandom_range(0, (1 << CSR_IDX_W) - NUM_REGS - 1)),
                     $urandom());
         load_regs();
         n_items = (p == 10) ? 150 : 120;
         repeat (n_items)
            pending_samples.push_back(pick_sample());
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_drive_q.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
